// ===== hdl/drp_pkg.sv =====
package drp_pkg;

  // Default buffer size in bytes; bytes at or beyond it are ignored.
  localparam int MAX_PACKET_BYTES_DEF = 548;

  // Fixed DHCP framing values.
  localparam int          HEADER_BYTES = 240;
  localparam logic [31:0] DHCP_COOKIE  = 32'h6382_5363;
  localparam logic [7:0]  REPLY_OP     = 8'd2;

  // Header byte positions.
  localparam int POS_OP         = 0;
  localparam int POS_XID_FIRST  = 4;
  localparam int POS_XID_LAST   = 7;
  localparam int POS_YIADDR_LO  = 16;
  localparam int POS_YIADDR_HI  = 19;
  localparam int POS_COOKIE_LO  = 236;
  localparam int POS_COOKIE_HI  = 239;

  // Option codes.
  localparam logic [7:0] OPT_PAD       = 8'd0;
  localparam logic [7:0] OPT_MASK      = 8'd1;
  localparam logic [7:0] OPT_ROUTER    = 8'd3;
  localparam logic [7:0] OPT_DNS       = 8'd6;
  localparam logic [7:0] OPT_MSG_TYPE  = 8'd53;
  localparam logic [7:0] OPT_SERVER_ID = 8'd54;
  localparam logic [7:0] OPT_END       = 8'd255;

  // Lease word slots.
  localparam int LEASE_WORDS  = 5;
  localparam int LW_ADDRESS   = 0;
  localparam int LW_MASK      = 1;
  localparam int LW_ROUTER    = 2;
  localparam int LW_DNS       = 3;
  localparam int LW_SERVER_ID = 4;

  // Configuration register indexes.
  localparam int          CFG_IDX_W        = 1;
  localparam logic [0:0]  CFG_EXPECTED_XID = 1'd0;
  localparam logic [0:0]  CFG_WANTED_TYPE  = 1'd1;
  localparam logic [31:0] XID_RESET        = 32'd1;
  localparam logic [7:0]  WANTED_RESET     = 8'd2;

  // Result status codes; ST_OK also means "no header fault".
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_NOT_REPLY = 3'd2,
    ST_XID       = 3'd3,
    ST_COOKIE    = 3'd4,
    ST_TRUNC     = 3'd5,
    ST_TYPE      = 3'd6
  } status_t;

  // Option walker phases.
  typedef enum logic [3:0] {
    PH_TYPE  = 4'b0001,
    PH_LEN   = 4'b0010,
    PH_VALUE = 4'b0100,
    PH_DONE  = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } drp_in_t;

  typedef struct packed {
    logic        accepted;
    status_t     status;
    logic [31:0] offered_address;
    logic [31:0] subnet_mask;
    logic [31:0] router_address;
    logic [31:0] dns_address;
    logic [31:0] server_id;
  } drp_out_t;

endpackage

// ===== hdl/drp_in_stage.sv =====
module drp_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  drp_pkg::drp_in_t  in_data,
  input  logic              out_busy,
  output logic              step,
  output drp_pkg::drp_in_t  item
);

  logic             valid_r;
  logic             valid_nxt;
  drp_pkg::drp_in_t item_r;

  // A held byte moves on unless it is a last byte and the result slot is stalled.
  assign step      = valid_r && !(item_r.last_byte && out_busy);
  assign in_ready  = !valid_r || step;
  assign valid_nxt = (in_valid && in_ready) || (valid_r && !step);
  assign item      = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload register loads on every accepted request.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

endmodule

// ===== hdl/drp_parse.sv =====
module drp_parse #(
  parameter int MAX_PACKET_BYTES = drp_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [drp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_wdata,
  input  logic                           step,
  input  drp_pkg::drp_in_t               item,
  output drp_pkg::drp_out_t              result
);

  localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_PACKET_BYTES);
  localparam logic [POS_W-1:0] POS_HDR = POS_W'(drp_pkg::HEADER_BYTES);

  logic [31:0]      xid_r;
  logic [7:0]       wanted_r;
  logic [POS_W-1:0] pos_r, pos_nxt;
  drp_pkg::status_t hfault_r, hfault_nxt;
  logic [31:0]      shadow_r, shadow_nxt;
  logic [31:0]      lease_r   [drp_pkg::LEASE_WORDS];
  logic [31:0]      lease_nxt [drp_pkg::LEASE_WORDS];
  drp_pkg::phase_t  phase_r, phase_nxt;
  logic [7:0]       code_r, code_nxt;
  logic [7:0]       rem_r, rem_nxt;
  logic [7:0]       len_r, len_nxt;
  logic [31:0]      vcap_r, vcap_nxt;
  logic [7:0]       seen_r, seen_nxt;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xid_r    <= drp_pkg::XID_RESET;
      wanted_r <= drp_pkg::WANTED_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        drp_pkg::CFG_EXPECTED_XID: xid_r    <= cfg_wdata;
        drp_pkg::CFG_WANTED_TYPE:  wanted_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Per-byte header check, option walk and result build.
  always_comb begin
    logic [7:0] b;
    logic       commit;
    logic [7:0] rem_dec;
    logic [7:0] taken;
    b          = item.data_byte;
    commit     = 1'b0;
    rem_dec    = rem_r - 8'd1;
    taken      = len_r - rem_r;
    pos_nxt    = pos_r;
    hfault_nxt = hfault_r;
    shadow_nxt = shadow_r;
    lease_nxt  = lease_r;
    phase_nxt  = phase_r;
    code_nxt   = code_r;
    rem_nxt    = rem_r;
    len_nxt    = len_r;
    vcap_nxt   = vcap_r;
    seen_nxt   = seen_r;
    result     = '0;

    if (step && (pos_r < POS_MAX)) begin
      pos_nxt = pos_r + POS_W'(1);
      if (pos_r < POS_HDR) begin
        // Fixed header fields.
        if (pos_r == POS_W'(drp_pkg::POS_OP) && b != drp_pkg::REPLY_OP &&
            hfault_r == drp_pkg::ST_OK) begin
          hfault_nxt = drp_pkg::ST_NOT_REPLY;
        end
        if (pos_r >= POS_W'(drp_pkg::POS_XID_FIRST) &&
            pos_r <= POS_W'(drp_pkg::POS_XID_LAST)) begin
          vcap_nxt = {vcap_r[23:0], b};
          if (pos_r == POS_W'(drp_pkg::POS_XID_LAST) && vcap_nxt != xid_r &&
              hfault_r == drp_pkg::ST_OK) begin
            hfault_nxt = drp_pkg::ST_XID;
          end
        end
        if (pos_r >= POS_W'(drp_pkg::POS_YIADDR_LO) &&
            pos_r <= POS_W'(drp_pkg::POS_YIADDR_HI)) begin
          shadow_nxt = {shadow_r[23:0], b};
        end
        if (pos_r == POS_W'(drp_pkg::POS_COOKIE_LO)) begin
          vcap_nxt = {24'd0, b};
        end else if (pos_r > POS_W'(drp_pkg::POS_COOKIE_LO) &&
                     pos_r <= POS_W'(drp_pkg::POS_COOKIE_HI)) begin
          vcap_nxt = {vcap_r[23:0], b};
        end
        if (pos_r == POS_W'(drp_pkg::POS_COOKIE_HI)) begin
          if (vcap_nxt != drp_pkg::DHCP_COOKIE && hfault_r == drp_pkg::ST_OK) begin
            hfault_nxt = drp_pkg::ST_COOKIE;
          end
          if (hfault_nxt == drp_pkg::ST_OK) begin
            lease_nxt[drp_pkg::LW_ADDRESS] = shadow_r;
          end
          vcap_nxt = '0;
        end
      end else if (hfault_r == drp_pkg::ST_OK) begin
        // Option walker.
        unique case (phase_r)
          drp_pkg::PH_TYPE: begin
            if (b == drp_pkg::OPT_END) begin
              phase_nxt = drp_pkg::PH_DONE;
            end else if (b != drp_pkg::OPT_PAD) begin
              code_nxt  = b;
              phase_nxt = drp_pkg::PH_LEN;
            end
          end
          drp_pkg::PH_LEN: begin
            len_nxt  = b;
            rem_nxt  = b;
            vcap_nxt = '0;
            // A zero-length option never matches a captured field.
            phase_nxt = (b == 8'd0) ? drp_pkg::PH_TYPE : drp_pkg::PH_VALUE;
          end
          drp_pkg::PH_VALUE: begin
            if (taken < 8'd4) begin
              vcap_nxt = {vcap_r[23:0], b};
            end
            rem_nxt = rem_dec;
            if (rem_dec == 8'd0) begin
              commit    = 1'b1;
              phase_nxt = drp_pkg::PH_TYPE;
            end
          end
          drp_pkg::PH_DONE: ;
          default: ;
        endcase
      end
    end

    // Commit a completed value option.
    if (commit) begin
      if (code_r == drp_pkg::OPT_MSG_TYPE && len_r == 8'd1) begin
        seen_nxt = vcap_nxt[7:0];
      end else if (len_r >= 8'd4) begin
        if (code_r == drp_pkg::OPT_MASK) begin
          lease_nxt[drp_pkg::LW_MASK] = vcap_nxt;
        end else if (code_r == drp_pkg::OPT_ROUTER) begin
          lease_nxt[drp_pkg::LW_ROUTER] = vcap_nxt;
        end else if (code_r == drp_pkg::OPT_DNS) begin
          lease_nxt[drp_pkg::LW_DNS] = vcap_nxt;
        end else if (code_r == drp_pkg::OPT_SERVER_ID) begin
          lease_nxt[drp_pkg::LW_SERVER_ID] = vcap_nxt;
        end
      end
    end

    // Status priority: short, header fault, truncated option, wrong type.
    priority if (pos_nxt < POS_HDR) begin
      result.status = drp_pkg::ST_SHORT;
    end else if (hfault_nxt != drp_pkg::ST_OK) begin
      result.status = hfault_nxt;
    end else if (phase_nxt == drp_pkg::PH_LEN || phase_nxt == drp_pkg::PH_VALUE) begin
      result.status = drp_pkg::ST_TRUNC;
    end else if (seen_nxt != wanted_r) begin
      result.status = drp_pkg::ST_TYPE;
    end else begin
      result.status = drp_pkg::ST_OK;
    end
    result.accepted        = (result.status == drp_pkg::ST_OK);
    result.offered_address = lease_nxt[drp_pkg::LW_ADDRESS];
    result.subnet_mask     = lease_nxt[drp_pkg::LW_MASK];
    result.router_address  = lease_nxt[drp_pkg::LW_ROUTER];
    result.dns_address     = lease_nxt[drp_pkg::LW_DNS];
    result.server_id       = lease_nxt[drp_pkg::LW_SERVER_ID];

    // The last byte closes the packet; the lease carries over.
    if (step && item.last_byte) begin
      pos_nxt    = '0;
      hfault_nxt = drp_pkg::ST_OK;
      shadow_nxt = '0;
      phase_nxt  = drp_pkg::PH_TYPE;
      code_nxt   = '0;
      rem_nxt    = '0;
      len_nxt    = '0;
      vcap_nxt   = '0;
      seen_nxt   = '0;
    end
  end

  // Packet and lease state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      hfault_r <= drp_pkg::ST_OK;
      shadow_r <= '0;
      lease_r  <= '{default: '0};
      phase_r  <= drp_pkg::PH_TYPE;
      code_r   <= '0;
      rem_r    <= '0;
      len_r    <= '0;
      vcap_r   <= '0;
      seen_r   <= '0;
    end else begin
      pos_r    <= pos_nxt;
      hfault_r <= hfault_nxt;
      shadow_r <= shadow_nxt;
      lease_r  <= lease_nxt;
      phase_r  <= phase_nxt;
      code_r   <= code_nxt;
      rem_r    <= rem_nxt;
      len_r    <= len_nxt;
      vcap_r   <= vcap_nxt;
      seen_r   <= seen_nxt;
    end
  end

endmodule

// ===== hdl/drp_out_stage.sv =====
module drp_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  drp_pkg::drp_out_t  result,
  input  logic               out_ready,
  output logic               out_valid,
  output drp_pkg::drp_out_t  out_data,
  output logic               out_busy
);

  logic              valid_r;
  logic              valid_nxt;
  drp_pkg::drp_out_t data_r;

  // The slot is busy while a result waits for a stalled receiver.
  assign out_busy  = valid_r && !out_ready;
  assign valid_nxt = load || out_busy;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

endmodule

// ===== hdl/dhcp_reply_parser_unit.sv =====
// DHCP reply parser.
// Input channel (in_valid/in_ready/in_data): one payload byte per request,
// with last_byte set on the final byte of the datagram. Result channel
// (out_valid/out_ready/out_data): one result per datagram, carrying the
// status, the accepted flag and the five lease words as they stand after
// the last byte. Configuration (cfg_we/cfg_index/cfg_wdata) sets the
// expected transaction id (index 0) and the wanted message type (index 1);
// write it only while no datagram is in flight.
// Throughput is one byte per cycle, except while a last byte waits for a busy
// result slot. A byte is held in the input register and the parser state
// updates as it leaves; the result is built from that update and loaded into
// the output register as the last byte leaves the input register.
// Reset clears the lease, the configuration to its defaults (id 1, type 2)
// and the per-datagram state. When the receiver stalls, a pending result
// holds; ordinary bytes keep flowing, and a further last byte waits in the
// input register until the result slot frees.
module dhcp_reply_parser_unit #(
  parameter int MAX_PACKET_BYTES = drp_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  drp_pkg::drp_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output drp_pkg::drp_out_t              out_data,
  input  logic                           cfg_we,
  input  logic [drp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_wdata
);

  logic              step;
  logic              out_busy;
  drp_pkg::drp_in_t  item;
  drp_pkg::drp_out_t result;

  drp_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_busy (out_busy),
    .step     (step),
    .item     (item)
  );

  drp_parse #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .item      (item),
    .result    (result)
  );

  drp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step && item.last_byte),
    .result    (result),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_busy  (out_busy)
  );

endmodule

// ===== hdl/drp_checker.sv =====
module drp_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input drp_pkg::drp_in_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input drp_pkg::drp_out_t out_data
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // The accepted flag agrees with the status code.
  a_accept_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.accepted == (out_data.status == drp_pkg::ST_OK)))
    else $error("accepted flag disagrees with status");

  // Reset leaves no result pending.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // With the result slot empty the input side is never held off.
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result slot");

  // A last byte accepted while no result is pending yields a result after the input and output registers.
  a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.last_byte && !out_valid |=> ##1 out_valid)
    else $error("no result after last byte");

endmodule

bind dhcp_reply_parser_unit drp_checker u_drp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
